// ----- hw/rtl/ising_metropolis_step_unit_macros.svh -----
// Assertion macros for the Ising Metropolis step unit.
`ifndef ISING_METROPOLIS_STEP_UNIT_MACROS_SVH
`define ISING_METROPOLIS_STEP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define IMSU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IMSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/imsu_pkg.sv -----
// Shared types and constants for the Ising Metropolis step unit.
package imsu_pkg;

	localparam int SideDefault = 64;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;
	localparam logic [0:0] RegThrFour  = 1'b0;
	localparam logic [0:0] RegThrEight = 1'b1;

	localparam int InTdataW  = 48;
	localparam int InTuserW  = 2;
	localparam int OutTdataW = 256;

	localparam int EnergyOutW = 15;
	localparam int MagOutW    = 14;
	localparam int SumEW      = 46;
	localparam int SumSqW     = 58;
	localparam int CntW       = 44;
	localparam int SweepW     = 32;
	localparam int FracW      = 32;

	localparam int EnergyOutMax = 16383;
	localparam int EnergyOutMin = -16384;
	localparam int MagOutMax    = 8191;
	localparam int MagOutMin    = -8192;

	typedef enum logic [1:0] {
		OpFlip  = 2'd0,
		OpLoad  = 2'd1,
		OpSweep = 2'd2
	} op_t;

	typedef struct packed {
		logic rd_a;
		logic rd_b;
		logic wr;
	} lat_ctrl_t;

endpackage

// ----- hw/rtl/imsu_lattice.sv -----
// Row-organized spin lattice memory with per-row valid bits.
module imsu_lattice #(
	parameter int SIDE = imsu_pkg::SideDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  imsu_pkg::lat_ctrl_t      ctrl,
	input  logic [$clog2(SIDE)-1:0]  addr_a,
	input  logic [$clog2(SIDE)-1:0]  addr_b,
	input  logic [$clog2(SIDE)-1:0]  wr_addr,
	input  logic [SIDE-1:0]          wr_row,
	output logic [SIDE-1:0]          row_a,
	output logic [SIDE-1:0]          row_b
);

	logic [SIDE-1:0] mem [SIDE];
	logic [SIDE-1:0] valid_q;
	logic [SIDE-1:0] da_q;
	logic [SIDE-1:0] db_q;
	logic            va_q;
	logic            vb_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[wr_addr] <= wr_row;
		end
		if (ctrl.rd_a) begin
			da_q <= mem[addr_a];
		end
		if (ctrl.rd_b) begin
			db_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (ctrl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_a) begin
				va_q <= valid_q[addr_a];
			end
			if (ctrl.rd_b) begin
				vb_q <= valid_q[addr_b];
			end
		end
	end

	// unwritten rows read as all spins up
	assign row_a = va_q ? da_q : '1;
	assign row_b = vb_q ? db_q : '1;

endmodule

// ----- hw/rtl/ising_metropolis_step_unit.sv -----
// Metropolis flip engine for a periodic 2D Ising lattice with sweep statistics.
//
// channel | dir | handshake                     | payload
// s_*     | in  | s_tvalid / s_tready           | s_tdata: col, row, rand_frac, spin_value
//         |     |                               | s_tuser: op
// m_*     | out | m_tvalid / m_tready           | m_tdata: result fields
// apb     | in  | psel & penable & pwrite       | threshold registers at 0x0, 0x4
//
// Each beat goes through the steps accept (read rows r and r-1), read row r+1, evaluate.
// The step order is set by the lattice memory: three row reads on two read ports.
// The next beat is accepted while a result still waits on m_*; evaluation holds
// until the output register is free.
// Reset is immediate: per-row valid bits stand in for the all-up lattice.
`include "ising_metropolis_step_unit_macros.svh"

module ising_metropolis_step_unit #(
	parameter int SIDE = imsu_pkg::SideDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [5:0] col, [11:6] row, [43:12] rand_frac, [44] spin_value, [47:45] zero
	input  logic [imsu_pkg::InTdataW-1:0] s_tdata,
	// [1:0] op
	input  logic [imsu_pkg::InTuserW-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] accepted, [15:1] energy, [29:16] magnetization, [75:30] sum_energy,
	// [133:76] sum_energy_sq, [177:134] sum_abs_mag, [221:178] accept_count,
	// [253:222] sweep_count, [255:254] zero
	output logic [imsu_pkg::OutTdataW-1:0] m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [imsu_pkg::CfgAddrW-1:0] paddr,
	input  logic [imsu_pkg::CfgDataW-1:0] pwdata,
	output logic [imsu_pkg::CfgDataW-1:0] prdata,
	output logic                          pready
);

	localparam int RowW = $clog2(SIDE);
	localparam int EnW  = 2 * RowW + 3;
	localparam int MgW  = 2 * RowW + 2;
	localparam int SqW  = 2 * EnW;
	localparam logic [RowW-1:0]        SideM1      = RowW'(SIDE - 1);
	localparam logic signed [EnW-1:0]  EnergyReset = EnW'(-2 * SIDE * SIDE);
	localparam logic signed [MgW-1:0]  MagReset    = MgW'(SIDE * SIDE);
	localparam logic signed [MgW-1:0]  MagStepUp   = MgW'(2);
	localparam logic signed [MgW-1:0]  MagStepDown = MgW'(-2);

	typedef enum logic [1:0] {
		StIdle,
		StMid,
		StEval
	} state_t;

	state_t                              state_q;
	imsu_pkg::op_t                       op_q;
	logic                                inside_q;
	logic [RowW-1:0]                     row_idx_q;
	logic [RowW-1:0]                     col_idx_q;
	logic [imsu_pkg::FracW-1:0]          rand_q;
	logic                                want_q;
	logic [SIDE-1:0]                     mid_q;
	logic [SqW-1:0]                      sq_s1;
	logic [MgW-1:0]                      abs_s1;
	logic                                m_tvalid_q;
	logic                                acc_q;
	logic signed [EnW-1:0]               energy_q;
	logic signed [MgW-1:0]               mag_q;
	logic signed [imsu_pkg::SumEW-1:0]   etot_q;
	logic [imsu_pkg::SumSqW-1:0]         sqtot_q;
	logic [imsu_pkg::CntW-1:0]           abstot_q;
	logic [imsu_pkg::CntW-1:0]           flips_q;
	logic [imsu_pkg::SweepW-1:0]         sweeps_q;
	logic [imsu_pkg::FracW-1:0]          thr4_q;
	logic [imsu_pkg::FracW-1:0]          thr8_q;

	logic [5:0]                          in_col;
	logic [5:0]                          in_row;
	logic                                in_inside;
	logic [RowW-1:0]                     in_row_idx;
	logic [RowW-1:0]                     in_col_idx;
	logic [RowW-1:0]                     in_up_idx;
	logic [RowW-1:0]                     dn_idx;
	logic                                s_accept;
	logic                                commit;
	imsu_pkg::lat_ctrl_t                 lat_ctrl;
	logic [RowW-1:0]                     lat_addr_a;
	logic [SIDE-1:0]                     row_a;
	logic [SIDE-1:0]                     row_b;
	logic [SIDE-1:0]                     wr_row;

	logic [RowW-1:0]                     col_l;
	logic [RowW-1:0]                     col_r;
	logic                                spin_c;
	logic [2:0]                          k_same;
	logic signed [4:0]                   de5;
	logic                                do_flip;
	logic signed [EnW-1:0]               energy_nxt;
	logic signed [MgW-1:0]               mag_nxt;
	logic signed [imsu_pkg::SumEW:0]     esum;
	logic signed [imsu_pkg::SumEW-1:0]   etot_nxt;
	logic [imsu_pkg::SumSqW:0]           sqsum;
	logic [imsu_pkg::CntW:0]             abssum;
	logic signed [31:0]                  e32;
	logic signed [31:0]                  m32;
	logic [imsu_pkg::EnergyOutW-1:0]     energy_out;
	logic [imsu_pkg::MagOutW-1:0]        mag_out;

	// input decode
	always_comb begin
		in_col     = s_tdata[5:0];
		in_row     = s_tdata[11:6];
		in_inside  = (32'(in_row) < SIDE) && (32'(in_col) < SIDE);
		in_row_idx = in_inside ? RowW'(in_row) : '0;
		in_col_idx = in_inside ? RowW'(in_col) : '0;
		in_up_idx  = (in_row_idx == '0) ? SideM1 : in_row_idx - RowW'(1);
		dn_idx     = (row_idx_q == SideM1) ? '0 : row_idx_q + RowW'(1);
	end

	assign s_tready = (state_q == StIdle);
	assign s_accept = s_tvalid && s_tready;
	assign commit   = (state_q == StEval) && (!m_tvalid_q || m_tready);

	// neighbour count and acceptance
	always_comb begin
		col_l  = (col_idx_q == '0) ? SideM1 : col_idx_q - RowW'(1);
		col_r  = (col_idx_q == SideM1) ? '0 : col_idx_q + RowW'(1);
		spin_c = mid_q[col_idx_q];
		k_same = 3'(mid_q[col_l] == spin_c) + 3'(mid_q[col_r] == spin_c) +
			3'(row_b[col_idx_q] == spin_c) + 3'(row_a[col_idx_q] == spin_c);
		de5    = 5'({k_same, 2'b00}) - 5'sd8;
		case (op_q)
			imsu_pkg::OpFlip: begin
				do_flip = inside_q && ((k_same <= 3'd2) ||
					((k_same == 3'd3) && (rand_q <= thr4_q)) ||
					((k_same == 3'd4) && (rand_q <= thr8_q)));
			end
			imsu_pkg::OpLoad: begin
				do_flip = inside_q && (spin_c != want_q);
			end
			default: begin
				do_flip = 1'b0;
			end
		endcase
		energy_nxt = energy_q + EnW'(de5);
		mag_nxt    = mag_q + (spin_c ? MagStepDown : MagStepUp);
		wr_row     = mid_q ^ (SIDE'(1) << col_idx_q);
	end

	// saturating sweep sums
	always_comb begin
		esum = (imsu_pkg::SumEW + 1)'(etot_q) + (imsu_pkg::SumEW + 1)'(energy_q);
		if (esum[imsu_pkg::SumEW] != esum[imsu_pkg::SumEW-1]) begin
			etot_nxt = esum[imsu_pkg::SumEW] ?
				{1'b1, {(imsu_pkg::SumEW-1){1'b0}}} : {1'b0, {(imsu_pkg::SumEW-1){1'b1}}};
		end else begin
			etot_nxt = esum[imsu_pkg::SumEW-1:0];
		end
		sqsum  = (imsu_pkg::SumSqW + 1)'(sqtot_q) + (imsu_pkg::SumSqW + 1)'(sq_s1);
		abssum = (imsu_pkg::CntW + 1)'(abstot_q) + (imsu_pkg::CntW + 1)'(abs_s1);
	end

	assign lat_ctrl.rd_a = s_accept || (state_q == StMid);
	assign lat_ctrl.rd_b = s_accept;
	assign lat_ctrl.wr   = commit && do_flip;
	assign lat_addr_a    = (state_q == StIdle) ? in_row_idx : dn_idx;

	imsu_lattice #(
		.SIDE(SIDE)
	) u_lattice (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lat_ctrl),
		.addr_a  (lat_addr_a),
		.addr_b  (in_up_idx),
		.wr_addr (row_idx_q),
		.wr_row  (wr_row),
		.row_a   (row_a),
		.row_b   (row_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			op_q       <= imsu_pkg::OpFlip;
			inside_q   <= 1'b0;
			row_idx_q  <= '0;
			col_idx_q  <= '0;
			rand_q     <= '0;
			want_q     <= 1'b0;
			mid_q      <= '0;
			sq_s1      <= '0;
			abs_s1     <= '0;
			m_tvalid_q <= 1'b0;
			acc_q      <= 1'b0;
			energy_q   <= EnergyReset;
			mag_q      <= MagReset;
			etot_q     <= '0;
			sqtot_q    <= '0;
			abstot_q   <= '0;
			flips_q    <= '0;
			sweeps_q   <= '0;
		end else begin
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (s_accept) begin
						op_q      <= imsu_pkg::op_t'(s_tuser);
						inside_q  <= in_inside;
						row_idx_q <= in_row_idx;
						col_idx_q <= in_col_idx;
						rand_q    <= s_tdata[43:12];
						want_q    <= s_tdata[44];
						state_q   <= StMid;
					end
				end
				StMid: begin
					mid_q   <= row_a;
					sq_s1   <= SqW'($unsigned(SqW'(energy_q) * SqW'(energy_q)));
					abs_s1  <= mag_q[MgW-1] ? MgW'(-mag_q) : MgW'(mag_q);
					state_q <= StEval;
				end
				StEval: begin
					if (commit) begin
						acc_q      <= do_flip;
						if (do_flip) begin
							energy_q <= energy_nxt;
							mag_q    <= mag_nxt;
						end
						if (do_flip && (op_q == imsu_pkg::OpFlip) && (flips_q != '1)) begin
							flips_q <= flips_q + 1'b1;
						end
						if (op_q == imsu_pkg::OpSweep) begin
							etot_q   <= etot_nxt;
							sqtot_q  <= sqsum[imsu_pkg::SumSqW] ? '1 : sqsum[imsu_pkg::SumSqW-1:0];
							abstot_q <= abssum[imsu_pkg::CntW] ? '1 : abssum[imsu_pkg::CntW-1:0];
							if (sweeps_q != '1) begin
								sweeps_q <= sweeps_q + 1'b1;
							end
						end
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// output clamp to field ranges
	always_comb begin
		e32 = 32'(energy_q);
		m32 = 32'(mag_q);
		if (e32 > imsu_pkg::EnergyOutMax) begin
			energy_out = imsu_pkg::EnergyOutW'(imsu_pkg::EnergyOutMax);
		end else if (e32 < imsu_pkg::EnergyOutMin) begin
			energy_out = imsu_pkg::EnergyOutW'(imsu_pkg::EnergyOutMin);
		end else begin
			energy_out = e32[imsu_pkg::EnergyOutW-1:0];
		end
		if (m32 > imsu_pkg::MagOutMax) begin
			mag_out = imsu_pkg::MagOutW'(imsu_pkg::MagOutMax);
		end else if (m32 < imsu_pkg::MagOutMin) begin
			mag_out = imsu_pkg::MagOutW'(imsu_pkg::MagOutMin);
		end else begin
			mag_out = m32[imsu_pkg::MagOutW-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, sweeps_q, flips_q, abstot_q, sqtot_q, etot_q,
		mag_out, energy_out, acc_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr4_q <= '0;
			thr8_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				imsu_pkg::RegThrFour: begin
					thr4_q <= pwdata;
				end
				imsu_pkg::RegThrEight: begin
					thr8_q <= pwdata;
				end
				default: begin
					thr4_q <= thr4_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			imsu_pkg::RegThrFour: begin
				prdata = thr4_q;
			end
			imsu_pkg::RegThrEight: begin
				prdata = thr8_q;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign pready = 1'b1;

	`IMSU_ASSERT_NEXT(a_single_beat_in_flight, s_accept, !s_tready, "beat accepted while busy")
	`IMSU_ASSERT_NEXT(a_state_held_without_commit, !commit, $stable(energy_q) && $stable(mag_q), "totals moved")
	`IMSU_ASSERT_SAME(a_flip_legal, commit && do_flip, inside_q && (op_q == imsu_pkg::OpFlip || op_q == imsu_pkg::OpLoad), "bad flip")

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the Ising Metropolis step unit: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import imsu_pkg::*;

	localparam logic [1:0] OpUnused = 2'd3;
	localparam logic [CfgAddrW-1:0] AddrThrFour  = {RegThrFour, 2'b00};
	localparam logic [CfgAddrW-1:0] AddrThrEight = {RegThrEight, 2'b00};
	localparam longint SumEHi = (longint'(1) << (SumEW - 1)) - 1;
	localparam longint SumELo = -SumEHi - 1;
	localparam longint unsigned SumSqMax = (64'd1 << SumSqW) - 1;
	localparam longint unsigned CntMax   = (64'd1 << CntW) - 1;
	localparam longint unsigned SweepMax = (64'd1 << SweepW) - 1;
	localparam int QuietLimit     = 4000;
	localparam int DrainCycles    = 12;
	localparam int RandomPerPhase = 110;
	localparam int DirectedRows   = 15;

	typedef struct packed {
		logic [1:0]  pad;
		logic [31:0] sweep_count;
		logic [43:0] accept_count;
		logic [43:0] sum_abs_mag;
		logic [57:0] sum_energy_sq;
		logic [45:0] sum_energy;
		logic [13:0] magnetization;
		logic [14:0] energy;
		logic        accepted;
	} lattice_result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [31:0] rnd;
		logic        spin;
		logic        typed;
		logic        acc;
		logic [14:0] energy;
		logic [13:0] mag;
	} site_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [InTdataW-1:0]   s_tdata;
	logic [InTuserW-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OutTdataW-1:0]  m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CfgAddrW-1:0]   paddr;
	logic [CfgDataW-1:0]   pwdata;
	logic [CfgDataW-1:0]   prdata;
	logic                  pready;

	bit                    spin_up [64][64];
	int                    energy_now;
	int                    magnet_now;
	longint                energy_sum;
	longint unsigned       energy_sq_sum;
	longint unsigned       abs_mag_sum;
	longint unsigned       flip_count;
	longint unsigned       sweep_total;
	logic [31:0]           thr_four;
	logic [31:0]           thr_eight;

	lattice_result_t       pending_lattice_results [$];
	int                    errors;
	int                    quiet_cycles = 0;
	int                    burst_left;
	int                    stall_mode = 0;
	int                    stall_run = 0;

	site_row_t directed_rows [DirectedRows] = '{
		'{OpFlip,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 15'(-8184), 14'(4094)},
		'{OpFlip,   6'd0,  6'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 15'(-8192), 14'(4096)},
		'{OpFlip,   6'd63, 6'd63, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 15'(-8192), 14'(4096)},
		'{OpLoad,   6'd5,  6'd5,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 15'(-8192), 14'(4096)},
		'{OpLoad,   6'd5,  6'd5,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 15'(-8184), 14'(4094)},
		'{OpFlip,   6'd6,  6'd5,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 15'(-8184), 14'(4094)},
		'{OpFlip,   6'd6,  6'd5,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 15'(-8180), 14'(4092)},
		'{OpSweep,  6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 15'(-8180), 14'(4092)},
		'{OpUnused, 6'd63, 6'd63, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpLoad,   6'd0,  6'd63, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpFlip,   6'd63, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpFlip,   6'd5,  6'd5,  32'h0000_1234, 1'b0, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpFlip,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpLoad,   6'd63, 6'd63, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 15'd0, 14'd0},
		'{OpSweep,  6'd0,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 15'd0, 14'd0}
	};

	ising_metropolis_step_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int spin_of(logic [5:0] row, logic [5:0] col);
		return spin_up[row][col] ? 1 : -1;
	endfunction

	function automatic int clamp_int(int v, int lo, int hi);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint unsigned sat_up(longint unsigned a, longint unsigned b,
			longint unsigned maxv);
		return (a > maxv || b > maxv - a) ? maxv : a + b;
	endfunction

	function automatic lattice_result_t metropolis_predict(logic [1:0] op, logic [5:0] col,
			logic [5:0] row, logic [31:0] rnd, logic spin);
		lattice_result_t res;
		int              here;
		int              around;
		int              delta;
		bit              flip_it;
		longint          e;
		longint          s;
		here   = spin_of(row, col);
		around = spin_of(row, col - 6'd1) + spin_of(row - 6'd1, col) +
			spin_of(row, col + 6'd1) + spin_of(row + 6'd1, col);
		delta   = 2 * here * around;
		flip_it = 1'b0;
		case (op)
			OpFlip: begin
				if (delta <= 0)
					flip_it = 1'b1;
				else if (delta == 4)
					flip_it = (rnd <= thr_four);
				else if (delta == 8)
					flip_it = (rnd <= thr_eight);
				if (flip_it)
					flip_count = sat_up(flip_count, 1, CntMax);
			end
			OpLoad: begin
				flip_it = (spin_up[row][col] != spin);
			end
			OpSweep: begin
				e = energy_now;
				s = energy_sum + e;
				energy_sum    = (s > SumEHi) ? SumEHi : ((s < SumELo) ? SumELo : s);
				energy_sq_sum = sat_up(energy_sq_sum, longint'(e * e), SumSqMax);
				abs_mag_sum   = sat_up(abs_mag_sum,
					longint'(magnet_now < 0 ? -magnet_now : magnet_now), CntMax);
				sweep_total   = sat_up(sweep_total, 1, SweepMax);
			end
			default: ;
		endcase
		if (flip_it) begin
			spin_up[row][col] = ~spin_up[row][col];
			magnet_now += spin_up[row][col] ? 2 : -2;
			energy_now += delta;
		end
		res.pad           = '0;
		res.accepted      = flip_it;
		res.energy        = 15'(clamp_int(energy_now, EnergyOutMin, EnergyOutMax));
		res.magnetization = 14'(clamp_int(magnet_now, MagOutMin, MagOutMax));
		res.sum_energy    = energy_sum[45:0];
		res.sum_energy_sq = energy_sq_sum[57:0];
		res.sum_abs_mag   = abs_mag_sum[43:0];
		res.accept_count  = flip_count[43:0];
		res.sweep_count   = sweep_total[31:0];
		return res;
	endfunction

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	task automatic write_threshold(logic [CfgAddrW-1:0] addr, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == AddrThrFour)
			thr_four = value;
		else
			thr_eight = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", 64'(value), 64'(prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_site_beat(logic [1:0] op, logic [5:0] col, logic [5:0] row,
			logic [31:0] rnd, logic spin);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, spin, rnd, row, col};
		s_tuser  <= op;
		burst_left--;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain_stream();
		@(negedge clk);
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (pending_lattice_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_run  <= $urandom_range(5, 40);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin : result_check
		lattice_result_t got;
		lattice_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_lattice_results.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: expected none actual %0h", $time, m_tdata);
			end else begin
				want = pending_lattice_results.pop_front();
				check_field("accepted", 64'(want.accepted), 64'(got.accepted));
				check_field("energy", 64'(want.energy), 64'(got.energy));
				check_field("magnetization", 64'(want.magnetization),
					64'(got.magnetization));
				check_field("sum_energy", 64'(want.sum_energy), 64'(got.sum_energy));
				check_field("sum_energy_sq", 64'(want.sum_energy_sq),
					64'(got.sum_energy_sq));
				check_field("sum_abs_mag", 64'(want.sum_abs_mag), 64'(got.sum_abs_mag));
				check_field("accept_count", 64'(want.accept_count),
					64'(got.accept_count));
				check_field("sweep_count", 64'(want.sweep_count), 64'(got.sweep_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		lattice_result_t want;
		logic [1:0]      op;
		logic [5:0]      col;
		logic [5:0]      row;
		logic [31:0]     rnd;
		int              pick;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		errors       = 0;
		burst_left   = 0;
		foreach (spin_up[r, c])
			spin_up[r][c] = 1'b1;
		energy_now    = -2 * 64 * 64;
		magnet_now    = 64 * 64;
		energy_sum    = 0;
		energy_sq_sum = 0;
		abs_mag_sum   = 0;
		flip_count    = 0;
		sweep_total   = 0;
		thr_four      = '0;
		thr_eight     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DirectedRows; i++) begin
			push_site_beat(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
				directed_rows[i].rnd, directed_rows[i].spin);
			want = metropolis_predict(directed_rows[i].op, directed_rows[i].col,
				directed_rows[i].row, directed_rows[i].rnd, directed_rows[i].spin);
			if (directed_rows[i].typed) begin
				want.accepted      = directed_rows[i].acc;
				want.energy        = directed_rows[i].energy;
				want.magnetization = directed_rows[i].mag;
			end
			pending_lattice_results.push_back(want);
		end
		drain_stream();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_threshold(AddrThrFour, 32'hFFFF_FFFF);
					write_threshold(AddrThrEight, 32'hFFFF_FFFF);
				end
				1: begin
					write_threshold(AddrThrFour, 32'h2000_0000);
					write_threshold(AddrThrEight, 32'h0400_0000);
				end
				2: begin
					write_threshold(AddrThrFour, 32'h0000_0000);
					write_threshold(AddrThrEight, 32'h0000_0000);
				end
				default: begin
					write_threshold(AddrThrFour, $urandom);
					write_threshold(AddrThrEight, $urandom);
				end
			endcase
			for (int n = 0; n < RandomPerPhase; n++) begin
				pick = $urandom_range(0, 99);
				op   = (pick < 64) ? OpFlip : (pick < 80) ? OpLoad :
					(pick < 94) ? OpSweep : OpUnused;
				if ($urandom_range(0, 2) != 0) begin
					row = 6'(62 + $urandom_range(0, 4));
					col = 6'(62 + $urandom_range(0, 4));
				end else begin
					row = 6'($urandom);
					col = 6'($urandom);
				end
				case ($urandom_range(0, 4))
					0: rnd = 32'h0000_0000;
					1: rnd = 32'hFFFF_FFFF;
					2: rnd = thr_four + 32'($urandom_range(0, 2)) - 32'd1;
					3: rnd = thr_eight + 32'($urandom_range(0, 2)) - 32'd1;
					default: rnd = $urandom;
				endcase
				push_site_beat(op, col, row, rnd, 1'($urandom));
				pending_lattice_results.push_back(
					metropolis_predict(op, col, row, rnd, s_tdata[44]));
			end
			drain_stream();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
